// ----- rtl/core/dpq_pkg.sv -----
// Shared types and constants for the palette quantizer core.
`timescale 1ns / 1ps
package dpq_pkg;
    localparam logic [1:0] ST_EMPTY  = 2'd0;
    localparam logic [1:0] ST_EXACT  = 2'd1;
    localparam logic [1:0] ST_APPROX = 2'd2;
    localparam logic [1:0] CFG_THRESH   = 2'd0;
    localparam logic [1:0] CFG_STREAK   = 2'd1;
    localparam logic [1:0] CFG_COOLDOWN = 2'd2;
    localparam logic [16:0] MISS_MAX = 17'h1FFFF;
    localparam logic [3:0] STREAK_MAX = 4'd15;
    localparam int KEY_BITS = 15;

    typedef struct packed {
        logic       eof;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_item;

    typedef enum logic [2:0] {
        BK_IDLE, BK_LOOK, BK_DEC, BK_SCAN, BK_SDRAIN, BK_OUT
    } t_bk_state;
endpackage

// ----- rtl/core/dpq_fifo.sv -----
// Short queue between the front and the back of the quantizer.
`timescale 1ns / 1ps
module dpq_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  dpq_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output dpq_pkg::t_item o_item
);
    import dpq_pkg::*;
    t_item      r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       push, pop;

    assign o_ready = (r_cnt != 3'd4);
    assign o_valid = (r_cnt != 3'd0);
    assign o_item  = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 2'd1;
            if (pop) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + {2'd0, push} - {2'd0, pop};
        end
    end
endmodule

// ----- rtl/core/dpq_front.sv -----
// Input stage: registers accepted transfers and forms the item.
`timescale 1ns / 1ps
module dpq_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic           i_operation,
    input  logic [7:0]     i_red,
    input  logic [7:0]     i_green,
    input  logic [7:0]     i_blue,
    output logic           o_valid,
    input  logic           i_ready,
    output dpq_pkg::t_item o_item
);
    import dpq_pkg::*;
    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= '{eof: i_operation, red: i_red, green: i_green, blue: i_blue};
        end
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end
endmodule

// ----- rtl/core/dpq_back.sv -----
// Back end: key cache, palette allocation, nearest scan, frame hysteresis.
`timescale 1ns / 1ps
module dpq_back #(
    parameter int KEY_ENTRIES   = 32768,
    parameter int PALETTE_SLOTS = 256
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  dpq_pkg::t_item i_item,
    input  logic [16:0]    i_thresh,
    input  logic [3:0]     i_streak,
    input  logic [7:0]     i_cooldown,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_slot_index,
    output logic           o_was_miss,
    output logic           o_dac_write,
    output logic [5:0]     o_dac_red,
    output logic [5:0]     o_dac_green,
    output logic [5:0]     o_dac_blue,
    output logic           o_rebuild_request
);
    import dpq_pkg::*;
    localparam int KW = $clog2(KEY_ENTRIES);
    localparam int PW = $clog2(PALETTE_SLOTS);
    localparam int SW = PW + 1;

    logic [7:0]  r_kslot [KEY_ENTRIES];
    logic [1:0]  r_kstat [KEY_ENTRIES];
    logic [23:0] r_pal   [PALETTE_SLOTS];

    t_bk_state r_st, n_st;
    logic        r_clr;
    logic [KW-1:0] r_clr_a;
    t_item       r_it;
    logic [KW-1:0] r_key;
    logic [7:0]  r_ks;
    logic [1:0]  r_kst;
    logic [SW-1:0] r_used;
    logic [16:0] r_miss;
    logic [3:0]  r_bad;
    logic [7:0]  r_cool;
    logic [PW:0] r_si;
    logic [23:0] r_pd;
    logic        r_pv;
    logic [PW-1:0] r_pi;
    logic [20:0] r_d;
    logic        r_dv;
    logic [PW-1:0] r_di;
    logic [20:0] r_best;
    logic [PW-1:0] r_bi;
    logic        r_ov;
    logic [7:0]  r_o_slot;
    logic        r_o_miss, r_o_dac, r_o_reb;
    logic [5:0]  r_o_r, r_o_g, r_o_b;

    logic [7:0]  n_o_slot;
    logic        n_o_miss, n_o_dac, n_o_reb;
    logic [5:0]  n_o_r, n_o_g, n_o_b;

    logic [KW-1:0] key_in;
    logic [14:0] key15;
    logic signed [8:0] dr, dg, db;
    logic [20:0] sq_dist;
    logic [7:0]  cl_dec;
    logic [3:0]  bad_inc;
    logic        bad, req;

    assign key15  = {i_item.red[7:3], i_item.green[7:3], i_item.blue[7:3]};
    assign key_in = key15[KW-1:0];
    assign o_ready = (r_st == BK_IDLE) && !r_clr && !r_ov;
    assign o_valid = r_ov;
    assign o_slot_index = r_o_slot;
    assign o_was_miss = r_o_miss;
    assign o_dac_write = r_o_dac;
    assign o_dac_red = r_o_r;
    assign o_dac_green = r_o_g;
    assign o_dac_blue = r_o_b;
    assign o_rebuild_request = r_o_reb;

    assign dr = $signed({1'b0, r_it.red})   - $signed({1'b0, r_pd[23:16]});
    assign dg = $signed({1'b0, r_it.green}) - $signed({1'b0, r_pd[15:8]});
    assign db = $signed({1'b0, r_it.blue})  - $signed({1'b0, r_pd[7:0]});
    always_comb begin
        logic signed [17:0] sr, sg, sb;
        sr = dr * dr;
        sg = dg * dg;
        sb = db * db;
        sq_dist = 21'(sr) * 21'd3 + 21'(sg) * 21'd6 + 21'(sb);
    end

    assign cl_dec  = (r_cool != 8'd0) ? r_cool - 8'd1 : r_cool;
    assign bad     = r_miss > i_thresh;
    assign bad_inc = (r_bad < STREAK_MAX) ? r_bad + 4'd1 : r_bad;
    assign req     = bad && (bad_inc >= i_streak) && (cl_dec == 8'd0);

    always_comb begin
        n_st = r_st;
        case (r_st)
            BK_IDLE:   if (i_valid && o_ready) n_st = i_item.eof ? BK_OUT : BK_LOOK;
            BK_LOOK:   n_st = BK_DEC;
            BK_DEC:    n_st = (r_kst == ST_EMPTY &&
                               r_used == SW'(PALETTE_SLOTS)) ? BK_SCAN : BK_OUT;
            BK_SCAN:   if (r_si == (PW+1)'(PALETTE_SLOTS - 1)) n_st = BK_SDRAIN;
            BK_SDRAIN: if (!r_pv && !r_dv) n_st = BK_OUT;
            BK_OUT:    n_st = BK_IDLE;
            default:   n_st = BK_IDLE;
        endcase
    end

    always_comb begin
        n_o_slot = '0;
        n_o_miss = 1'b0;
        n_o_dac  = 1'b0;
        n_o_r    = '0;
        n_o_g    = '0;
        n_o_b    = '0;
        n_o_reb  = 1'b0;
        if (r_it.eof) begin
            n_o_reb = req;
        end else if (r_kst != ST_EMPTY) begin
            n_o_slot = r_ks;
            n_o_miss = (r_kst == ST_APPROX);
        end else if (r_used != SW'(PALETTE_SLOTS)) begin
            n_o_slot = 8'(r_used);
            n_o_dac  = 1'b1;
            n_o_r    = r_it.red[7:2];
            n_o_g    = r_it.green[7:2];
            n_o_b    = r_it.blue[7:2];
        end else begin
            n_o_slot = 8'(r_bi);
            n_o_miss = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == BK_IDLE && i_valid && o_ready) begin
            r_it  <= i_item;
            r_key <= key_in;
        end
        if (r_st == BK_LOOK) begin
            r_ks  <= r_kslot[r_key];
            r_kst <= r_kstat[r_key];
        end
        r_pd <= r_pal[r_si[PW-1:0]];
        r_pi <= r_si[PW-1:0];
        r_d  <= sq_dist;
        r_di <= r_pi;
        if (r_clr) begin
            r_kstat[r_clr_a] <= ST_EMPTY;
        end else if (r_st == BK_DEC && r_kst == ST_EMPTY && r_used != SW'(PALETTE_SLOTS)) begin
            r_kstat[r_key] <= ST_EXACT;
            r_kslot[r_key] <= 8'(r_used);
        end else if (r_st == BK_SDRAIN && !r_pv && !r_dv) begin
            r_kstat[r_key] <= ST_APPROX;
            r_kslot[r_key] <= 8'(r_bi);
        end
        if (r_st == BK_DEC && r_kst == ST_EMPTY && r_used != SW'(PALETTE_SLOTS)) begin
            r_pal[r_used[PW-1:0]] <= {r_it.red, r_it.green, r_it.blue};
        end
        if (!i_rst_n) begin
            r_st <= BK_IDLE;
            r_clr <= 1'b1;
            r_clr_a <= '0;
            r_used <= '0;
            r_miss <= '0;
            r_bad <= '0;
            r_cool <= '0;
            r_ov <= 1'b0;
            r_pv <= 1'b0;
            r_dv <= 1'b0;
            r_si <= '0;
        end else begin
            r_st <= n_st;
            if (r_clr) begin
                r_clr_a <= r_clr_a + KW'(1);
                if (r_clr_a == KW'(KEY_ENTRIES - 1)) r_clr <= 1'b0;
            end
            r_pv <= (r_st == BK_SCAN);
            r_dv <= r_pv;
            if (r_st == BK_DEC) begin
                r_si <= '0;
            end else if (r_st == BK_SCAN) begin
                r_si <= r_si + (PW+1)'(1);
            end
            if (r_st == BK_DEC) begin
                r_best <= 21'h1FFFFF;
                r_bi <= '0;
            end else if (r_dv && r_d < r_best) begin
                r_best <= r_d;
                r_bi <= r_di;
            end
            if (r_st == BK_OUT) begin
                r_ov <= 1'b1;
            end else if (r_ov && i_ready) begin
                r_ov <= 1'b0;
            end
            if (r_st == BK_OUT) begin
                r_o_slot <= n_o_slot;
                r_o_miss <= n_o_miss;
                r_o_dac  <= n_o_dac;
                r_o_r    <= n_o_r;
                r_o_g    <= n_o_g;
                r_o_b    <= n_o_b;
                r_o_reb  <= n_o_reb;
                if (r_it.eof) begin
                    r_miss <= '0;
                    if (req) begin
                        r_bad <= '0;
                        r_cool <= i_cooldown;
                    end else begin
                        r_bad <= bad ? bad_inc : 4'd0;
                        r_cool <= cl_dec;
                    end
                end else if (n_o_miss && r_miss != MISS_MAX) begin
                    r_miss <= r_miss + 17'd1;
                end
                if (n_o_dac) r_used <= r_used + SW'(1);
            end
        end
    end
endmodule

// ----- rtl/core/dynamic_palette_color_quantizer_core.sv -----
// Top level of the dynamic palette color quantizer.
// Input channel: i_valid/o_ready with i_operation (0 pixel, 1 frame end)
// and 8-bit red, green, blue. Output channel: o_valid/i_ready with slot,
// miss flag, DAC write and channels, and the rebuild request.
// Config: i_cfg_we, i_cfg_index, i_cfg_data, to be written while idle (not enforced).
// Items pass an input register and a four-entry queue, then the back end
// handles one item at a time: a frame end goes straight to the output
// state, a cache hit or new slot passes the lookup and decode states, and a
// nearest-color miss also scans the palette through its single read port,
// one slot per cycle, and drains the distance pipeline before the output state.
// After reset the key status memory is cleared, one entry a cycle, over all
// KEY_ENTRIES entries; items wait in the queue meanwhile.
// A stalled receiver holds the result register; the back end then stops,
// and the queue and input register fill before o_ready drops.
`timescale 1ns / 1ps
module dynamic_palette_color_quantizer_core #(
    parameter int KEY_ENTRIES   = 32768,
    parameter int PALETTE_SLOTS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_operation,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_slot_index,
    output logic        o_was_miss,
    output logic        o_dac_write,
    output logic [5:0]  o_dac_red,
    output logic [5:0]  o_dac_green,
    output logic [5:0]  o_dac_blue,
    output logic        o_rebuild_request,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data
);
    import dpq_pkg::*;
    logic [16:0] r_thresh;
    logic [3:0]  r_streak;
    logic [7:0]  r_cool;
    logic        f_valid, f_ready, q_valid, q_ready;
    t_item       f_item, q_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= 17'd1000;
            r_streak <= 4'd3;
            r_cool   <= 8'd16;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_THRESH:   r_thresh <= i_cfg_data;
                CFG_STREAK:   r_streak <= i_cfg_data[3:0];
                CFG_COOLDOWN: r_cool   <= i_cfg_data[7:0];
                default:      ;
            endcase
        end
    end

    dpq_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_operation, .i_red, .i_green, .i_blue,
        .o_valid(f_valid), .i_ready(f_ready), .o_item(f_item)
    );

    dpq_fifo u_fifo (
        .i_clk, .i_rst_n,
        .i_valid(f_valid), .o_ready(f_ready), .i_item(f_item),
        .o_valid(q_valid), .i_ready(q_ready), .o_item(q_item)
    );

    dpq_back #(.KEY_ENTRIES(KEY_ENTRIES), .PALETTE_SLOTS(PALETTE_SLOTS)) u_back (
        .i_clk, .i_rst_n,
        .i_valid(q_valid), .o_ready(q_ready), .i_item(q_item),
        .i_thresh(r_thresh), .i_streak(r_streak), .i_cooldown(r_cool),
        .o_valid, .i_ready, .o_slot_index, .o_was_miss, .o_dac_write,
        .o_dac_red, .o_dac_green, .o_dac_blue, .o_rebuild_request
    );
endmodule

// ----- bench/tb_dynamic_palette_color_quantizer_core.sv -----
// Self-checking bench for the palette quantizer core: directed and random traffic, scoreboard check.
`timescale 1ns / 1ps
module tb_dynamic_palette_color_quantizer_core;
    import dpq_pkg::*;

    localparam int KEYS  = 32768;
    localparam int SLOTS = 256;

    typedef struct packed {
        logic [7:0] slot;
        logic       miss;
        logic       dac_we;
        logic [5:0] dr;
        logic [5:0] dg;
        logic [5:0] db;
        logic       rebuild;
    } t_quant_result;

    class palette_scoreboard;
        logic [7:0]  key_slot [KEYS];
        logic [1:0]  key_status [KEYS];
        logic [7:0]  pal_r [SLOTS];
        logic [7:0]  pal_g [SLOTS];
        logic [7:0]  pal_b [SLOTS];
        int          slots_used;
        logic [16:0] miss_count;
        logic [3:0]  bad_streak;
        logic [7:0]  cooldown_left;
        logic [16:0] thresh;
        logic [3:0]  streak_needed;
        logic [7:0]  cooldown_frames;
        t_quant_result pending_q [$];
        int          errors;

        function new();
            foreach (key_status[k]) key_status[k] = ST_EMPTY;
            slots_used = 0;
            miss_count = '0;
            bad_streak = '0;
            cooldown_left = '0;
            thresh = 17'd1000;
            streak_needed = 4'd3;
            cooldown_frames = 8'd16;
            errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [16:0] val);
            case (idx)
                CFG_THRESH:   thresh = val;
                CFG_STREAK:   streak_needed = val[3:0];
                CFG_COOLDOWN: cooldown_frames = val[7:0];
                default: ;
            endcase
        endfunction

        function int nearest(logic [7:0] r, logic [7:0] g, logic [7:0] b);
            int best;
            int bi;
            int d;
            int er;
            int eg;
            int eb;
            best = 32'h7FFFFFFF;
            bi = 0;
            for (int i = 0; i < SLOTS; i++) begin
                er = int'(r) - int'(pal_r[i]);
                eg = int'(g) - int'(pal_g[i]);
                eb = int'(b) - int'(pal_b[i]);
                d = 3 * er * er + 6 * eg * eg + eb * eb;
                if (d < best) begin
                    best = d;
                    bi = i;
                end
            end
            return bi;
        endfunction

        function void bump_miss();
            if (miss_count != MISS_MAX) miss_count++;
        endfunction

        function void note_transfer(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
            t_quant_result e;
            int key;
            e = '{8'd0, 1'b0, 1'b0, 6'd0, 6'd0, 6'd0, 1'b0};
            if (op) begin
                if (cooldown_left != 0) cooldown_left--;
                if (miss_count > thresh) begin
                    if (bad_streak != STREAK_MAX) bad_streak++;
                    if (bad_streak >= streak_needed && cooldown_left == 0) begin
                        e.rebuild = 1'b1;
                        bad_streak = '0;
                        cooldown_left = cooldown_frames;
                    end
                end else begin
                    bad_streak = '0;
                end
                miss_count = '0;
            end else begin
                key = int'({r[7:3], g[7:3], b[7:3]});
                if (key_status[key] != ST_EMPTY) begin
                    e.slot = key_slot[key];
                    if (key_status[key] == ST_APPROX) begin
                        bump_miss();
                        e.miss = 1'b1;
                    end
                end else if (slots_used < SLOTS) begin
                    pal_r[slots_used] = r;
                    pal_g[slots_used] = g;
                    pal_b[slots_used] = b;
                    e.slot = slots_used[7:0];
                    e.dac_we = 1'b1;
                    e.dr = r[7:2];
                    e.dg = g[7:2];
                    e.db = b[7:2];
                    slots_used++;
                    key_status[key] = ST_EXACT;
                    key_slot[key] = e.slot;
                end else begin
                    e.slot = 8'(nearest(r, g, b));
                    e.miss = 1'b1;
                    bump_miss();
                    key_status[key] = ST_APPROX;
                    key_slot[key] = e.slot;
                end
            end
            pending_q.push_back(e);
        endfunction

        function void check_result(t_quant_result a);
            t_quant_result e;
            if (pending_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result slot=%0d", a.slot);
                return;
            end
            e = pending_q.pop_front();
            if (a != e) begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch exp slot=%0d miss=%b dac=%b %h/%h/%h rb=%b",
                              "  got slot=%0d miss=%b dac=%b %h/%h/%h rb=%b"},
                             e.slot, e.miss, e.dac_we, e.dr, e.dg, e.db, e.rebuild,
                             a.slot, a.miss, a.dac_we, a.dr, a.dg, a.db, a.rebuild);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_operation = 1'b0;
    logic [7:0]  i_red = '0;
    logic [7:0]  i_green = '0;
    logic [7:0]  i_blue = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [7:0]  o_slot_index;
    logic        o_was_miss;
    logic        o_dac_write;
    logic [5:0]  o_dac_red;
    logic [5:0]  o_dac_green;
    logic [5:0]  o_dac_blue;
    logic        o_rebuild_request;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [16:0] i_cfg_data = '0;

    palette_scoreboard sb = new();
    logic [23:0] seen_colors [$];
    bit          calm = 1'b0;
    bit          hold_off_req = 1'b0;
    bit          rx_enable = 1'b0;

    always #1 i_clk = ~i_clk;

    dynamic_palette_color_quantizer_core u_dut (.*);

    initial begin
        #4_000_000;
        $display("tb_dynamic_palette_color_quantizer_core: FAIL");
        $finish;
    end

    // receiver: random stalls plus one long hold-off
    initial begin
        int hold;
        hold = 0;
        wait (rx_enable);
        forever begin
            @(negedge i_clk);
            if (hold_off_req && hold == 0) begin
                hold = 400;
                hold_off_req = 1'b0;
            end
            if (hold > 0) begin
                hold--;
                i_ready = 1'b0;
            end else begin
                i_ready = calm || ($urandom_range(99) >= 24);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_result('{o_slot_index, o_was_miss, o_dac_write, o_dac_red,
                              o_dac_green, o_dac_blue, o_rebuild_request});
    end

    task automatic send(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        if (!calm && $urandom_range(99) < 24) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_operation = op;
        i_red = r;
        i_green = g;
        i_blue = b;
        do @(posedge i_clk); while (!o_ready);
        sb.note_transfer(op, r, g, b);
        if (!op) seen_colors.push_back({r, g, b});
        @(negedge i_clk);
    endtask

    task automatic wait_drain();
        i_valid = 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [16:0] val);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic random_item();
        int k;
        logic [23:0] c;
        k = $urandom_range(99);
        if (k < 8) begin
            send(1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
        end else if (k < 70 && seen_colors.size() > 0) begin
            c = seen_colors[$urandom_range(seen_colors.size() - 1)];
            send(1'b0, {c[23:19], 3'($urandom)}, {c[15:11], 3'($urandom)},
                 {c[7:3], 3'($urandom)});
        end else begin
            send(1'b0, 8'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) begin
            if (i % 100 == 0) calm = (i == 100) || ($urandom_range(3) == 0);
            random_item();
        end
        calm = 1'b0;
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        rx_enable = 1'b1;

        // directed: extremes, repeats, same key with other low bits, frame ends
        send(1'b0, 8'h00, 8'h00, 8'h00);
        send(1'b0, 8'hFF, 8'hFF, 8'hFF);
        send(1'b0, 8'h00, 8'h00, 8'h00);
        send(1'b0, 8'h07, 8'h07, 8'h07);
        send(1'b0, 8'hF8, 8'hFF, 8'hFC);
        send(1'b1, 8'hFF, 8'hFF, 8'hFF);
        send(1'b0, 8'hFF, 8'h00, 8'h00);
        send(1'b0, 8'h00, 8'hFF, 8'h00);
        send(1'b0, 8'h00, 8'h00, 8'hFF);
        send(1'b0, 8'hAA, 8'h55, 8'hAA);
        send(1'b0, 8'h55, 8'hAA, 8'h55);
        send(1'b1, 8'h00, 8'h00, 8'h00);

        // fill the palette
        while (sb.slots_used < SLOTS)
            send(1'b0, 8'($urandom), 8'($urandom), 8'($urandom));
        wait_drain();

        // full palette: nearest matches, approximate hits, frame-end checks
        write_reg(CFG_THRESH, 17'd0);
        write_reg(CFG_STREAK, 17'd1);
        write_reg(CFG_COOLDOWN, 17'd0);
        send(1'b0, 8'h01, 8'h80, 8'hFE);
        send(1'b0, 8'h01, 8'h80, 8'hFE);
        send(1'b1, 8'h00, 8'h00, 8'h00);
        send(1'b1, 8'h00, 8'h00, 8'h00);
        random_phase(250);
        wait_drain();

        write_reg(CFG_THRESH, 17'h1FFFF);
        write_reg(CFG_STREAK, 17'd15);
        write_reg(CFG_COOLDOWN, 17'd255);
        hold_off_req = 1'b1;
        random_phase(200);
        wait_drain();

        write_reg(CFG_THRESH, 17'd2);
        write_reg(CFG_STREAK, 17'd0);
        write_reg(CFG_COOLDOWN, 17'd3);
        random_phase(250);
        wait_drain();

        write_reg(CFG_THRESH, 17'($urandom_range(1, 4)));
        write_reg(CFG_STREAK, 17'($urandom_range(2, 4)));
        write_reg(CFG_COOLDOWN, 17'($urandom_range(1, 8)));
        random_phase(300);
        wait_drain();

        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("tb_dynamic_palette_color_quantizer_core: PASS");
        else
            $display("tb_dynamic_palette_color_quantizer_core: FAIL");
        $finish;
    end
endmodule

// ----- dynamic_palette_color_quantizer_core.f -----
rtl/core/dpq_pkg.sv
rtl/core/dpq_fifo.sv
rtl/core/dpq_front.sv
rtl/core/dpq_back.sv
rtl/core/dynamic_palette_color_quantizer_core.sv
bench/tb_dynamic_palette_color_quantizer_core.sv
